>>> hw/rtl/esd_pkg.sv
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types and constants for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_QUOTE_A = 2'd0;
    localparam logic [1:0] CFG_QUOTE_B = 2'd1;
    localparam logic [1:0] CFG_BACKREF = 2'd2;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_BSLASH   = 3'd1,
        MODE_CTRL     = 3'd2,
        MODE_HEXSTART = 3'd3,
        MODE_HEX      = 3'd4,
        MODE_OCT      = 3'd5,
        MODE_IGNORE   = 3'd6
    } t_mode;

    typedef struct packed {
        logic [7:0] quote_a;
        logic [7:0] quote_b;
        logic       backref;
    } t_cfg;

    typedef struct packed {
        t_mode      mode;
        logic       brace;
        logic [7:0] num;
        logic       nz;
        logic [1:0] cont;
        logic       stopped;
    } t_dec_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_marker;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        t_out_item [MAX_RES-1:0] item;
        logic [1:0]              cnt;
    } t_res_list;

endpackage

>>> hw/rtl/esd_decode.sv
// ----------------------------------------------------------------------------
// esd_decode
// Parser state and combinational decode of one byte into up to three results.
// ----------------------------------------------------------------------------
module esd_decode import esd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_cfg       i_cfg,
    output t_res_list  o_res
);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam t_dec_state ST_RESET = '{mode: MODE_NORMAL, brace: 1'b0, num: 8'h00,
                                        nz: 1'b0, cont: 2'd0, stopped: 1'b0};

    typedef struct packed {
        t_dec_state st;
        t_res_list  res;
        logic       reparse;
    } t_work;

    t_dec_state r_state;
    t_dec_state n_state;
    t_work      w;

    function automatic t_work push_res(t_work wi, logic [7:0] b, logic e);
        t_work wo;
        wo = wi;
        if (wo.res.cnt != 2'(MAX_RES)) begin
            wo.res.item[wo.res.cnt].out_byte   = b;
            wo.res.item[wo.res.cnt].end_marker = e;
            wo.res.item[wo.res.cnt].run_last   = 1'b0;
            wo.res.cnt = wo.res.cnt + 2'd1;
        end
        return wo;
    endfunction

    function automatic t_work emit(t_work wi, logic [7:0] b);
        t_work wo;
        wo = wi;
        if (!wo.st.stopped) begin
            if (b == CH_NUL) begin
                wo.st.stopped = 1'b1;
            end else begin
                wo = push_res(wo, b, 1'b0);
            end
        end
        return wo;
    endfunction

    function automatic t_work clear_num(t_work wi);
        t_work wo;
        wo = wi;
        wo.st.num   = 8'h00;
        wo.st.nz    = 1'b0;
        wo.st.brace = 1'b0;
        return wo;
    endfunction

    function automatic t_work emit_number(t_work wi);
        t_work wo;
        wo = wi;
        if (wo.st.nz) begin
            wo = emit(wo, wo.st.num);
        end
        wo = clear_num(wo);
        wo.st.mode = MODE_NORMAL;
        return wo;
    endfunction

    function automatic t_work flush(t_work wi);
        t_work wo;
        wo = wi;
        case (wo.st.mode)
            MODE_BSLASH: wo = emit(wo, CH_BSLASH);
            MODE_HEX, MODE_OCT: wo = emit_number(wo);
            default: ;
        endcase
        wo = clear_num(wo);
        wo.st.cont = 2'd0;
        wo.st.mode = MODE_NORMAL;
        return wo;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic t_work after_backslash(t_work wi, logic [7:0] c, t_cfg cfg);
        t_work wo;
        wo = wi;
        wo.st.mode = MODE_NORMAL;
        if ((cfg.quote_a != CH_NUL && c == cfg.quote_a) ||
            (cfg.quote_b != CH_NUL && c == cfg.quote_b)) begin
            wo = emit(wo, c);
        end else begin
            case (c)
                8'h61: wo = emit(wo, 8'h07);
                8'h65: wo = emit(wo, 8'h1B);
                8'h66: wo = emit(wo, 8'h0C);
                8'h6E: wo = emit(wo, 8'h0A);
                8'h72: wo = emit(wo, 8'h0D);
                8'h74: wo = emit(wo, 8'h09);
                8'h76: wo = emit(wo, 8'h0B);
                8'h27, 8'h22, CH_BSLASH: wo = emit(wo, c);
                8'h63: wo.st.mode = MODE_CTRL;
                8'h78, 8'h58: begin
                    wo = clear_num(wo);
                    wo.st.mode = MODE_HEXSTART;
                end
                8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37: begin
                    if (c != CH_ZERO && cfg.backref) begin
                        wo = emit(wo, CH_BSLASH);
                        wo = emit(wo, c);
                    end else begin
                        wo = clear_num(wo);
                        wo.st.num  = {5'd0, c[2:0]};
                        wo.st.nz   = (c != CH_ZERO);
                        wo.st.mode = MODE_OCT;
                    end
                end
                default: begin
                    wo = emit(wo, CH_BSLASH);
                    wo = emit(wo, c);
                end
            endcase
        end
        return wo;
    endfunction

    function automatic t_work take_byte(t_work wi, logic [7:0] c, t_cfg cfg);
        t_work      wo;
        logic [4:0] hv;
        wo = wi;
        wo.reparse = 1'b0;
        hv = hex_value(c);
        case (wo.st.mode)
            MODE_NORMAL: begin
                if (wo.st.cont != 2'd0) begin
                    wo.st.cont = wo.st.cont - 2'd1;
                    wo = emit(wo, c);
                end else if (c == CH_BSLASH) begin
                    wo.st.mode = MODE_BSLASH;
                end else begin
                    if ((c & 8'hE0) == 8'hC0) begin
                        wo.st.cont = 2'd1;
                    end else if ((c & 8'hF0) == 8'hE0) begin
                        wo.st.cont = 2'd2;
                    end else if ((c & 8'hF8) == 8'hF0) begin
                        wo.st.cont = 2'd3;
                    end
                    wo = emit(wo, c);
                end
            end
            MODE_BSLASH: wo = after_backslash(wo, c, cfg);
            MODE_CTRL: begin
                wo.st.mode = MODE_NORMAL;
                if (c == CH_AT) begin
                    wo = emit(wo, CH_NUL);
                end else if (c inside {[8'h41:8'h5F]}) begin
                    wo = emit(wo, c - 8'h40);
                end else if (c inside {[8'h61:8'h7A]}) begin
                    wo = emit(wo, c - 8'h60);
                end else if (c == CH_QMARK) begin
                    wo = emit(wo, CH_DEL);
                end else begin
                    wo.reparse = 1'b1;
                end
            end
            MODE_HEXSTART, MODE_HEX: begin
                if (wo.st.mode == MODE_HEXSTART && c == CH_LBRACE) begin
                    wo.st.mode  = MODE_HEX;
                    wo.st.brace = 1'b1;
                end else begin
                    wo.st.mode = MODE_HEX;
                    if (hv[4]) begin
                        wo.st.num = {wo.st.num[3:0], hv[3:0]};
                        if (hv[3:0] != 4'd0) begin
                            wo.st.nz = 1'b1;
                        end
                    end else if (c == CH_RBRACE && wo.st.brace) begin
                        wo = emit_number(wo);
                    end else begin
                        wo = emit_number(wo);
                        wo.reparse = 1'b1;
                    end
                end
            end
            MODE_OCT: begin
                if (c inside {[8'h30:8'h37]}) begin
                    wo.st.num = {wo.st.num[4:0], c[2:0]};
                    if (c != CH_ZERO) begin
                        wo.st.nz = 1'b1;
                    end
                end else begin
                    wo = emit_number(wo);
                    wo.reparse = 1'b1;
                end
            end
            default: ;
        endcase
        return wo;
    endfunction

    always_comb begin
        w.st      = r_state;
        w.res     = '0;
        w.reparse = 1'b0;
        if (w.st.mode != MODE_IGNORE) begin
            if (i_byte == CH_NUL) begin
                w = flush(w);
                w.st.mode = MODE_IGNORE;
            end else begin
                w = take_byte(w, i_byte, i_cfg);
                if (w.reparse) begin
                    w = take_byte(w, i_byte, i_cfg);
                end
            end
        end
        if (i_last) begin
            if (w.st.mode != MODE_IGNORE) begin
                w = flush(w);
            end
            w = push_res(w, CH_NUL, 1'b1);
            w.st = ST_RESET;
        end
        if (w.res.cnt != 2'd0) begin
            w.res.item[w.res.cnt - 2'd1].run_last = 1'b1;
        end
        n_state = w.st;
        o_res   = w.res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RESET;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |-> o_res.cnt != 2'd0 && o_res.item[o_res.cnt - 2'd1].end_marker)
        else $error("last item does not end with an end marker");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_last |-> !o_res.item[0].end_marker || o_res.cnt == 2'd0)
        else $error("end marker without last item");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |=> r_state.mode == MODE_NORMAL && !r_state.stopped)
        else $error("parser not back in normal mode after last item");

endmodule

>>> hw/rtl/esd_out_fifo.sv
// ----------------------------------------------------------------------------
// esd_out_fifo
// Result queue: takes up to three results per cycle, hands out one per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module esd_out_fifo import esd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_res_list  i_res,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_item  o_item
);

    t_out_item          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [1:0]         push_n;
    logic               pop;

    assign push_n  = i_push ? i_res.cnt : 2'd0;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= CNT_W'(FIFO_DEPTH - MAX_RES));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (i_push && 2'(k) < i_res.cnt) begin
                r_mem[r_wr_ptr + PTR_W'(k)] <= i_res.item[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count + CNT_W'(i_res.cnt)) <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

endmodule

>>> hw/rtl/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Backslash escape decoder for a byte stream, one input byte per cycle while the result queue has room.
// ----------------------------------------------------------------------------
// An accepted byte lands in an input register and is decoded from there, in
// one pass, into zero to three results once the four-entry result queue has
// room; the results are registered in the queue, whose head entry drives the
// output port. The input takes one byte per cycle as long as each byte gives
// at most one result and the output is drained every cycle. A byte that gives
// several results hands them out one per output transfer, and decoding stalls
// while the queue holds more than one result; the input then stalls once its
// register holds a byte. Configuration writes take effect on the next cycle
// and are expected only while the block is idle.
module escape_sequence_decoder import esd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_end_marker,
    output logic       o_run_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_cfg       r_cfg;
    logic       dec_fire;
    logic       room;
    t_res_list  dec_res;
    t_out_item  head;

    assign dec_fire    = r_in_valid && room;
    assign o_in_ready  = !r_in_valid || dec_fire;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_QUOTE_A: r_cfg.quote_a <= i_cfg_data;
                CFG_QUOTE_B: r_cfg.quote_b <= i_cfg_data;
                CFG_BACKREF: r_cfg.backref <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    esd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (dec_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_cfg   (r_cfg),
        .o_res   (dec_res)
    );

    esd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dec_fire),
        .i_res   (dec_res),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (head)
    );

    assign o_out_byte   = head.out_byte;
    assign o_end_marker = head.end_marker;
    assign o_run_last   = head.run_last;

endmodule

>>> test/escape_sequence_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_decoder_tb
// Self-checking bench for the backslash escape decoder. A scoreboard class
// holds its own copy of the decoder state and registers, predicts the output
// bytes and end markers of every input transfer, and checks each output
// transfer in order. Stimulus is a directed string set followed by random
// escape sequences under several register settings, with random stalls on
// both channels, a long output hold-off and drains between settings.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_tb import esd_pkg::*; ();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 64;

    class decode_scoreboard;
        t_out_item  expected_q[$];
        int         errors;
        logic [7:0] quote_a;
        logic [7:0] quote_b;
        logic       backref;
        t_mode      mode;
        logic       brace;
        logic [7:0] num;
        logic       nz;
        logic [1:0] cont;
        logic       stopped;
        logic [7:0] step_byte [MAX_RES];
        logic       step_end [MAX_RES];
        int         step_n;

        function new();
            errors  = 0;
            quote_a = 8'h00;
            quote_b = 8'h00;
            backref = 1'b0;
            clear_state();
        endfunction

        function void clear_state();
            mode    = MODE_NORMAL;
            brace   = 1'b0;
            num     = 8'h00;
            nz      = 1'b0;
            cont    = 2'd0;
            stopped = 1'b0;
        endfunction

        function void write_register(logic [1:0] idx, logic [7:0] data);
            case (idx)
                CFG_QUOTE_A: quote_a = data;
                CFG_QUOTE_B: quote_b = data;
                CFG_BACKREF: backref = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void put(logic [7:0] b, logic e);
            if (step_n < MAX_RES) begin
                step_byte[step_n] = b;
                step_end[step_n]  = e;
                step_n++;
            end
        endfunction

        function void emit_byte(logic [7:0] b);
            if (stopped)
                return;
            if (b == 8'h00) begin
                stopped = 1'b1;
                return;
            end
            put(b, 1'b0);
        endfunction

        function void clear_number();
            num   = 8'h00;
            nz    = 1'b0;
            brace = 1'b0;
        endfunction

        function void end_number();
            if (nz)
                emit_byte(num);
            clear_number();
            mode = MODE_NORMAL;
        endfunction

        function void flush();
            case (mode)
                MODE_BSLASH: emit_byte(8'h5C);
                MODE_HEX, MODE_OCT: end_number();
                default: ;
            endcase
            clear_number();
            cont = 2'd0;
            mode = MODE_NORMAL;
        endfunction

        function void escaped(logic [7:0] c);
            mode = MODE_NORMAL;
            if ((quote_a != 8'h00 && c == quote_a) || (quote_b != 8'h00 && c == quote_b)) begin
                emit_byte(c);
                return;
            end
            case (c)
                "a": emit_byte(8'h07);
                "e": emit_byte(8'h1B);
                "f": emit_byte(8'h0C);
                "n": emit_byte(8'h0A);
                "r": emit_byte(8'h0D);
                "t": emit_byte(8'h09);
                "v": emit_byte(8'h0B);
                "'", "\"", "\\": emit_byte(c);
                "c": mode = MODE_CTRL;
                "x", "X": begin
                    clear_number();
                    mode = MODE_HEXSTART;
                end
                "0", "1", "2", "3", "4", "5", "6", "7": begin
                    if (c != "0" && backref) begin
                        emit_byte(8'h5C);
                        emit_byte(c);
                    end else begin
                        clear_number();
                        num  = c - 8'h30;
                        nz   = (c != "0");
                        mode = MODE_OCT;
                    end
                end
                default: begin
                    emit_byte(8'h5C);
                    emit_byte(c);
                end
            endcase
        endfunction

        // returns 1 when the byte ends the number and is parsed again
        function bit hex_step(logic [7:0] c);
            int v;
            v = -1;
            if (c >= "0" && c <= "9") v = c - 8'h30;
            else if (c >= "A" && c <= "F") v = c - 8'h37;
            else if (c >= "a" && c <= "f") v = c - 8'h57;
            if (v >= 0) begin
                num = {num[3:0], v[3:0]};
                if (v != 0)
                    nz = 1'b1;
                return 1'b0;
            end
            if (c == "}" && brace) begin
                end_number();
                return 1'b0;
            end
            end_number();
            return 1'b1;
        endfunction

        function bit take(logic [7:0] c);
            case (mode)
                MODE_NORMAL: begin
                    if (cont != 2'd0) begin
                        cont--;
                        emit_byte(c);
                    end else if (c == 8'h5C) begin
                        mode = MODE_BSLASH;
                    end else begin
                        if ((c & 8'hE0) == 8'hC0) cont = 2'd1;
                        else if ((c & 8'hF0) == 8'hE0) cont = 2'd2;
                        else if ((c & 8'hF8) == 8'hF0) cont = 2'd3;
                        emit_byte(c);
                    end
                    return 1'b0;
                end
                MODE_BSLASH: begin
                    escaped(c);
                    return 1'b0;
                end
                MODE_CTRL: begin
                    mode = MODE_NORMAL;
                    if (c == "@") emit_byte(8'h00);
                    else if (c >= "A" && c <= "_") emit_byte(c - 8'h40);
                    else if (c >= "a" && c <= "z") emit_byte(c - 8'h60);
                    else if (c == "?") emit_byte(8'h7F);
                    else return 1'b1;
                    return 1'b0;
                end
                MODE_HEXSTART: begin
                    mode = MODE_HEX;
                    if (c == "{") begin
                        brace = 1'b1;
                        return 1'b0;
                    end
                    return hex_step(c);
                end
                MODE_HEX: return hex_step(c);
                MODE_OCT: begin
                    if (c >= "0" && c <= "7") begin
                        num = {num[4:0], c[2:0]};
                        if (c != "0")
                            nz = 1'b1;
                        return 1'b0;
                    end
                    end_number();
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_input(logic [7:0] c, logic last);
            t_out_item item;
            step_n = 0;
            if (mode != MODE_IGNORE) begin
                if (c == 8'h00) begin
                    flush();
                    mode = MODE_IGNORE;
                end else if (take(c)) begin
                    void'(take(c));
                end
            end
            if (last) begin
                if (mode != MODE_IGNORE)
                    flush();
                put(8'h00, 1'b1);
                clear_state();
            end
            for (int i = 0; i < step_n; i++) begin
                item.out_byte   = step_byte[i];
                item.end_marker = step_end[i];
                item.run_last   = (i == step_n - 1);
                expected_q.push_back(item);
            end
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic [7:0] b, logic e, logic r);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer byte %02h end %0b last %0b", b, e, r));
                return;
            end
            want = expected_q.pop_front();
            if (b !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h", b, want.out_byte));
            if (e !== want.end_marker)
                report_mismatch($sformatf("end_marker %0b, want %0b", e, want.end_marker));
            if (r !== want.run_last)
                report_mismatch($sformatf("run_last %0b, want %0b", r, want.run_last));
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_end_marker;
    logic       o_run_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    decode_scoreboard sb;
    int    cycle_count = 0;
    int    sent = 0;
    int    hold_left = 0;
    int    stall_left = 0;
    bit    idle_on = 1'b1;
    string hex_digits = "0123456789ABCDEFabcdef";
    string named_letters = "aefnrtv'\"\\";

    logic [7:0] directed_text [26] = '{
        8'h5C, "n",
        8'h5C, "c", "1",
        8'h5C, "x", "{", "4", "1", "}",
        8'h5C, "1", "2", "z",
        8'hE2, 8'h82, 8'hAC,
        8'h5C, 8'hFF,
        8'h5C, "c", "@", "A",
        8'h00,
        8'h5C
    };

    escape_sequence_decoder DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_end_marker (o_end_marker),
        .o_run_last   (o_run_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_input(i_in_byte, i_in_last);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_byte, o_end_marker, o_run_last);
        end
    end

    // output side: long hold-off on request, else short random stalls
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        i_in_last  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic push_char(input logic [7:0] c);
        send_byte(c, $urandom_range(0, 19) == 0);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] qa, input logic [7:0] qb, input logic br);
        cfg_write(CFG_QUOTE_A, qa);
        cfg_write(CFG_QUOTE_B, qb);
        cfg_write(CFG_BACKREF, {7'd0, br});
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every expected transfer, then let silent bytes finish decoding
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_token();
        int         kind;
        int         n;
        bit         braced;
        logic [7:0] c;
        kind = $urandom_range(0, 19);
        case (kind)
            0, 1, 2, 3, 19: push_char(8'($urandom_range(1, 255)));
            4, 5: begin
                push_char(8'h5C);
                push_char(8'(named_letters[$urandom_range(0, 9)]));
            end
            6: begin
                c = $urandom_range(0, 1) ? sb.quote_a : sb.quote_b;
                if (c == 8'h00)
                    c = "t";
                push_char(8'h5C);
                push_char(c);
            end
            7, 8: begin
                push_char(8'h5C);
                push_char("c");
                if ($urandom_range(0, 3) == 0)
                    push_char(8'($urandom_range(1, 255)));
                else
                    push_char(8'($urandom_range(8'h3F, 8'h7A)));
            end
            9, 10, 11: begin
                push_char(8'h5C);
                push_char($urandom_range(0, 1) ? "x" : "X");
                braced = $urandom_range(0, 1);
                if (braced)
                    push_char("{");
                n = $urandom_range(0, 3);
                repeat (n) push_char(8'(hex_digits[$urandom_range(0, 21)]));
                if (braced && $urandom_range(0, 3) != 0)
                    push_char("}");
            end
            12, 13: begin
                push_char(8'h5C);
                n = $urandom_range(1, 3);
                repeat (n) push_char(8'(8'h30 + $urandom_range(0, 7)));
            end
            14, 15: begin
                n = $urandom_range(1, 3);
                case (n)
                    1: c = 8'hC0 | 8'($urandom_range(0, 31));
                    2: c = 8'hE0 | 8'($urandom_range(0, 15));
                    default: c = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                push_char(c);
                repeat (n) push_char(8'h80 | 8'($urandom_range(0, 63)));
            end
            16: begin
                push_char(8'h5C);
                push_char(8'($urandom_range(1, 255)));
            end
            17: begin
                if ($urandom_range(0, 3) == 0)
                    push_char(8'h00);
                else
                    push_char(8'($urandom_range(1, 255)));
            end
            default: send_byte(8'($urandom_range(1, 255)), 1'b1);
        endcase
    endtask

    initial begin
        int goal;
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_in_last   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_QUOTE_A;
        i_cfg_data  = 8'h00;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // quote byte overriding a named letter, top byte as second quote
        write_cfg("n", 8'hFF, 1'b0);
        for (int i = 0; i < 26; i++)
            send_byte(directed_text[i], i == 25);
        settle();

        // back references, dangling backslash at end of string
        write_cfg(8'h00, 8'h00, 1'b1);
        send_byte(8'h5C, 1'b0);
        send_byte("5", 1'b1);
        send_byte(8'h5C, 1'b1);

        for (int p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: write_cfg(8'h00, 8'h00, 1'b0);
                1: write_cfg(8'hFF, 8'hFF, 1'b1);
                2: write_cfg("'", "x", 1'b0);
                3: write_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                4: write_cfg("c", "7", 1'b1);
                default: write_cfg(8'($urandom_range(1, 255)), 8'h00,
                                   1'($urandom_range(0, 1)));
            endcase
            if (p == 1)
                hold_left = HOLD_CYCLES;
            idle_on = (p != 5);
            goal = sent + RANDOM_ITEMS / 6;
            while (sent < goal)
                random_token();
        end
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/esd_pkg.sv
hw/rtl/esd_decode.sv
hw/rtl/esd_out_fifo.sv
hw/rtl/escape_sequence_decoder.sv
test/escape_sequence_decoder_tb.sv
